/* rtl/abkf_pkg.sv */
// shared types, constants and helpers for the angle/bias kalman filter
package abkf_pkg;

    localparam int CFG_W = 31;
    localparam int IDX_W = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_ANGLE_Q = 2'd0;
    localparam logic [IDX_W-1:0] REG_BIAS_Q  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MEAS_R  = 2'd2;
    localparam logic [IDX_W-1:0] REG_DT      = 2'd3;

    localparam logic [CFG_W-1:0] RST_ANGLE_Q = 31'd1073742;
    localparam logic [CFG_W-1:0] RST_BIAS_Q  = 31'd3221225;
    localparam logic [CFG_W-1:0] RST_MEAS_R  = 31'd1288490189;
    localparam logic [CFG_W-1:0] RST_DT      = 31'd10737418;

    localparam logic signed [31:0] QONE = 32'sd1073741824;

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
        logic signed [31:0] r;
        if (x > 34'sd2147483647) r = 32'sh7fffffff;
        else if (x < -34'sd2147483648) r = 32'sh80000000;
        else r = x[31:0];
        return r;
    endfunction

    // saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) r = 32'sh7fffffff;
        else if (x < -64'sd2147483648) r = 32'sh80000000;
        else r = x[31:0];
        return r;
    endfunction

endpackage

/* rtl/abkf_mulq.sv */
// shared signed 33x32 multiplier, rounded scale-down by 2^30, registered output
module abkf_mulq (
    input  logic               aclk,
    input  logic signed [32:0] a,
    input  logic signed [31:0] b,
    output logic signed [34:0] y
);
    logic signed [64:0] prod_reg;
    logic        [64:0] mag;
    logic        [64:0] rnd;
    logic signed [34:0] y_next;
    logic signed [34:0] y_reg;

    // registered product
    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    // round half away from zero on the magnitude
    always_comb begin
        mag = prod_reg[64] ? 65'(-prod_reg) : 65'(prod_reg);
        rnd = (mag + 65'(1 << 29)) >> 30;
        y_next = prod_reg[64] ? -35'(rnd[34:0]) : 35'(rnd[34:0]);
    end

    always_ff @(posedge aclk) begin
        y_reg <= y_next;
    end

    assign y = y_reg;
endmodule

/* rtl/abkf_div.sv */
// restoring divider: signed 32-bit numerator times 2^30 over positive 33-bit denominator
module abkf_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic        [32:0] den,
    output logic               done,
    output logic signed [31:0] quo
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic [61:0] dividend_reg, dividend_next;
    logic [33:0] rem_reg, rem_next;
    logic [61:0] q_reg, q_next;
    logic [32:0] den_reg, den_next;
    logic [33:0] trial;
    logic [62:0] qmag;
    logic        done_reg, done_next;

    // one quotient bit per cycle, 62 bits
    always_comb begin
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        dividend_next = dividend_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        den_next = den_reg;
        done_next = 1'b0;
        trial = {rem_reg[32:0], dividend_reg[61]} - {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next = 6'd0;
            neg_next = num[31];
            dividend_next = {(num[31] ? 32'(-num) : 32'(num)), 30'd0};
            rem_next = '0;
            q_next = '0;
            den_next = den;
        end else if (busy_reg) begin
            dividend_next = {dividend_reg[60:0], 1'b0};
            if (!trial[33]) begin
                rem_next = trial;
                q_next = {q_reg[60:0], 1'b1};
            end else begin
                rem_next = {rem_reg[32:0], dividend_reg[61]};
                q_next = {q_reg[60:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd61) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        neg_reg <= neg_next;
        dividend_reg <= dividend_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        den_reg <= den_next;
    end

    // truncation toward zero then saturation
    assign qmag = {1'b0, q_reg};
    assign quo = abkf_pkg::sat64(neg_reg ? -64'(qmag) : 64'(qmag));
    assign done = done_reg;
endmodule

/* rtl/angle_bias_kalman_filter.sv */
// top level: two-state angle and gyro bias kalman filter
// Usage: one item on s_ (accel angle Q9.16, gyro rate Q12.16) gives one item
// on m_ (filtered angle, bias-corrected rate, bias, Q16.16). Configuration
// registers (angle noise, bias noise, measurement noise, sample period; unsigned
// Q1.30) are written through cfg_we/cfg_index/cfg_data while no item is in flight.
// Sequence: the prediction products on one shared multiplier, each through
// operands, product and rounded result, a check of the innovation variance,
// the two gains in turn in the bit-serial divider, the correction products
// (ten products in all) and a load of the output register.
// With a non-positive innovation variance the gains are zero and the divider
// is skipped.
// Flow: s_ready is high only while the sequencer is idle, so an item is taken
// only after the previous one has been loaded into the output register.
// The result waits in an output register until m_ready; the next item may be
// computed meanwhile, but its result is held back until that register is
// free and s_ready stays low until then.
// Reset: synchronous active-low aresetn restores the default registers,
// zero angle and bias and identity covariance; no result is pending.
module angle_bias_kalman_filter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [24:0] s_accel_angle,
    input  logic signed [27:0] s_gyro_rate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_filtered_angle,
    output logic signed [31:0] m_corrected_rate,
    output logic signed [31:0] m_bias_estimate
);
    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_GAIN = 3'd2;
    localparam logic [2:0] ST_DIV0 = 3'd3;
    localparam logic [2:0] ST_DIV1 = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // multiply steps, in order
    localparam logic [3:0] OP_ANG_PRED  = 4'd0;
    localparam logic [3:0] OP_P00_PRED  = 4'd1;
    localparam logic [3:0] OP_P01_PRED  = 4'd2;
    localparam logic [3:0] OP_P11_PRED  = 4'd3;
    localparam logic [3:0] OP_P10_CORR  = 4'd4;
    localparam logic [3:0] OP_P11_CORR  = 4'd5;
    localparam logic [3:0] OP_P00_CORR  = 4'd6;
    localparam logic [3:0] OP_P01_CORR  = 4'd7;
    localparam logic [3:0] OP_ANG_CORR  = 4'd8;
    localparam logic [3:0] OP_BIAS_CORR = 4'd9;

    logic [30:0] aq_reg, bq_reg, mr_reg, dt_reg;
    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] k0_reg, k1_reg, err_reg;
    logic signed [24:0] acc_reg;
    logic signed [27:0] gyr_reg;
    logic [2:0] st_reg;
    logic [3:0] op_reg;
    logic [1:0] wait_reg;
    logic       out_valid_reg, out_valid_next;
    logic       out_load;
    logic signed [31:0] o_ang_reg, o_rate_reg, o_bias_reg;

    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [34:0] mul_y;
    logic               div_start;
    logic signed [31:0] div_num;
    logic        [32:0] den;
    logic               div_done;
    logic signed [31:0] div_q;
    logic signed [33:0] e_sum;
    logic               e_pos;
    logic signed [31:0] d0;
    logic signed [31:0] rate_diff;
    logic signed [31:0] dt_s;

    abkf_mulq u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .y(mul_y));

    abkf_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(den), .done(div_done), .quo(div_q)
    );

    // innovation variance, angle covariance derivative and rate difference
    assign e_sum = 34'(signed'({1'b0, mr_reg})) + 34'(p00_reg);
    assign e_pos = (e_sum > 34'sd0);
    assign den = e_sum[32:0];
    assign d0 = abkf_pkg::sat34(34'(signed'({1'b0, aq_reg})) - 34'(p01_reg)
                                - 34'(p10_reg));
    assign rate_diff = abkf_pkg::sat34(34'(gyr_reg) - 34'(bias_reg));
    assign dt_s = signed'({1'b0, dt_reg});

    // operand select per multiply step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            OP_ANG_PRED: begin mul_a = 33'(rate_diff); mul_b = dt_s; end
            OP_P00_PRED: begin mul_a = 33'(d0); mul_b = dt_s; end
            OP_P01_PRED: begin mul_a = -33'(p11_reg); mul_b = dt_s; end
            OP_P11_PRED: begin mul_a = 33'(signed'({1'b0, bq_reg})); mul_b = dt_s; end
            OP_P10_CORR: begin mul_a = 33'(k1_reg); mul_b = p00_reg; end
            OP_P11_CORR: begin mul_a = 33'(k1_reg); mul_b = p01_reg; end
            OP_P00_CORR: begin mul_a = 33'(k0_reg); mul_b = p00_reg; end
            OP_P01_CORR: begin mul_a = 33'(k0_reg); mul_b = p01_reg; end
            OP_ANG_CORR: begin mul_a = 33'(k0_reg); mul_b = err_reg; end
            OP_BIAS_CORR: begin mul_a = 33'(k1_reg); mul_b = err_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // angle gain first, bias gain started as soon as the first is done
    assign div_start = (st_reg == ST_GAIN && e_pos) || (st_reg == ST_DIV0 && div_done);
    assign div_num = (st_reg == ST_DIV0) ? p10_reg : p00_reg;

    assign s_ready = (st_reg == ST_IDLE);

    // output register: load when free or being taken
    always_comb begin
        out_load = (st_reg == ST_OUT) && (!out_valid_reg || m_ready);
        out_valid_next = out_valid_reg;
        if (out_load) out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
    end

    // sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            op_reg <= '0;
            wait_reg <= '0;
            out_valid_reg <= 1'b0;
            aq_reg <= abkf_pkg::RST_ANGLE_Q;
            bq_reg <= abkf_pkg::RST_BIAS_Q;
            mr_reg <= abkf_pkg::RST_MEAS_R;
            dt_reg <= abkf_pkg::RST_DT;
            ang_reg <= '0;
            bias_reg <= '0;
            p00_reg <= abkf_pkg::QONE;
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= abkf_pkg::QONE;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    abkf_pkg::REG_ANGLE_Q: aq_reg <= cfg_data;
                    abkf_pkg::REG_BIAS_Q:  bq_reg <= cfg_data;
                    abkf_pkg::REG_MEAS_R:  mr_reg <= cfg_data;
                    abkf_pkg::REG_DT:      dt_reg <= cfg_data;
                    default: ;
                endcase
            end
            out_valid_reg <= out_valid_next;
            case (st_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        acc_reg <= s_accel_angle;
                        gyr_reg <= s_gyro_rate;
                        op_reg <= OP_ANG_PRED;
                        wait_reg <= 2'd0;
                        st_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // rounded product is ready once the operands have passed the product and result registers
                    if (wait_reg != 2'd2) begin
                        wait_reg <= wait_reg + 2'd1;
                    end else begin
                        wait_reg <= 2'd0;
                        case (op_reg)
                            OP_ANG_PRED: ang_reg <= abkf_pkg::sat34(34'(ang_reg) + 34'(mul_y));
                            OP_P00_PRED: p00_reg <= abkf_pkg::sat34(34'(p00_reg) + 34'(mul_y));
                            OP_P01_PRED: begin
                                p01_reg <= abkf_pkg::sat34(34'(p01_reg) + 34'(mul_y));
                                p10_reg <= abkf_pkg::sat34(34'(p10_reg) + 34'(mul_y));
                            end
                            OP_P11_PRED: begin
                                p11_reg <= abkf_pkg::sat34(34'(p11_reg) + 34'(mul_y));
                                err_reg <= abkf_pkg::sat34(34'(acc_reg) - 34'(ang_reg));
                            end
                            OP_P10_CORR: p10_reg <= abkf_pkg::sat34(34'(p10_reg) - 34'(mul_y));
                            OP_P11_CORR: p11_reg <= abkf_pkg::sat34(34'(p11_reg) - 34'(mul_y));
                            OP_P00_CORR: p00_reg <= abkf_pkg::sat34(34'(p00_reg) - 34'(mul_y));
                            OP_P01_CORR: p01_reg <= abkf_pkg::sat34(34'(p01_reg) - 34'(mul_y));
                            OP_ANG_CORR: ang_reg <= abkf_pkg::sat34(34'(ang_reg) + 34'(mul_y));
                            OP_BIAS_CORR: begin
                                bias_reg <= abkf_pkg::sat34(34'(bias_reg) + 34'(mul_y));
                            end
                            default: ;
                        endcase
                        if (op_reg == OP_P11_PRED) begin
                            st_reg <= ST_GAIN;
                        end else if (op_reg == OP_BIAS_CORR) begin
                            st_reg <= ST_OUT;
                        end else begin
                            op_reg <= op_reg + 4'd1;
                        end
                    end
                end
                ST_GAIN: begin
                    // non-positive innovation variance: zero gains, no correction
                    if (e_pos) begin
                        st_reg <= ST_DIV0;
                    end else begin
                        k0_reg <= '0;
                        k1_reg <= '0;
                        op_reg <= OP_P10_CORR;
                        st_reg <= ST_MUL;
                    end
                end
                ST_DIV0: begin
                    if (div_done) begin
                        k0_reg <= div_q;
                        st_reg <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        k1_reg <= div_q;
                        op_reg <= OP_P10_CORR;
                        st_reg <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        o_ang_reg <= ang_reg;
                        o_bias_reg <= bias_reg;
                        o_rate_reg <= rate_diff;
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_filtered_angle = o_ang_reg;
    assign m_corrected_rate = o_rate_reg;
    assign m_bias_estimate = o_bias_reg;
endmodule

/* sim/tb_top.sv */
// self-checking testbench for the angle and gyro bias kalman filter
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ACCEL_MAX  = 11796480;
    localparam int GYRO_MAX   = 131072000;
    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_LEN   = 700;
    localparam int ITEMS_PER_PHASE = 104;

    typedef struct {
        int accel;
        int gyro;
        bit typed;
        int fa;
        int cr;
        int be;
    } stim_row_t;

    typedef struct {
        int fa;
        int cr;
        int be;
    } imu_out_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [30:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [24:0] s_accel_angle;
    logic signed [27:0] s_gyro_rate;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_filtered_angle;
    logic signed [31:0] m_corrected_rate;
    logic signed [31:0] m_bias_estimate;

    // filter state mirrored by the predictor
    longint q_angle, q_bias, r_meas, dt_step;
    longint ang_st, bias_st;
    longint cov_st [4];

    imu_out_t  pending_q [$];
    stim_row_t dir_tab [$];
    bit        row_typed;
    imu_out_t  row_exp;

    int  err_cnt;
    int  items_in;
    int  items_out;
    int  idle_cycles = 0;
    bit  hold_req;
    int  burst_left;

    angle_bias_kalman_filter u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_accel_angle    (s_accel_angle),
        .s_gyro_rate      (s_gyro_rate),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_angle (m_filtered_angle),
        .m_corrected_rate (m_corrected_rate),
        .m_bias_estimate  (m_bias_estimate)
    );

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // q30 product, rounded to nearest with halves away from zero
    function automatic longint qmul(input longint a, input longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + (64'sd1 <<< 29)) >>> 30;
        return (p < 0) ? -m : m;
    endfunction

    function automatic void reset_filter_model();
        q_angle = abkf_pkg::RST_ANGLE_Q;
        q_bias  = abkf_pkg::RST_BIAS_Q;
        r_meas  = abkf_pkg::RST_MEAS_R;
        dt_step = abkf_pkg::RST_DT;
        ang_st  = 0;
        bias_st = 0;
        cov_st[0] = 64'sd1073741824;
        cov_st[1] = 0;
        cov_st[2] = 0;
        cov_st[3] = 64'sd1073741824;
    endfunction

    // one predict and correct step of the filter
    function automatic imu_out_t kalman_step(input longint accel, input longint gyro);
        longint p00, p01, p10, p11, d0, d1, innov, e, k0, k1;
        imu_out_t r;
        ang_st = clamp32(ang_st + qmul(clamp32(gyro - bias_st), dt_step));
        p00 = cov_st[0];
        p01 = cov_st[1];
        p10 = cov_st[2];
        p11 = cov_st[3];
        d0  = clamp32(q_angle - p01 - p10);
        d1  = qmul(-p11, dt_step);
        p00 = clamp32(p00 + qmul(d0, dt_step));
        p01 = clamp32(p01 + d1);
        p10 = clamp32(p10 + d1);
        p11 = clamp32(p11 + qmul(q_bias, dt_step));
        innov = clamp32(accel - ang_st);
        e = r_meas + p00;
        // no correction when innovation variance is not positive
        if (e > 0) begin
            k0 = clamp32((p00 * 64'sd1073741824) / e);
            k1 = clamp32((p10 * 64'sd1073741824) / e);
        end else begin
            k0 = 0;
            k1 = 0;
        end
        cov_st[0] = clamp32(p00 - qmul(k0, p00));
        cov_st[1] = clamp32(p01 - qmul(k0, p01));
        cov_st[2] = clamp32(p10 - qmul(k1, p00));
        cov_st[3] = clamp32(p11 - qmul(k1, p01));
        ang_st  = clamp32(ang_st + qmul(k0, innov));
        bias_st = clamp32(bias_st + qmul(k1, innov));
        r.fa = int'(ang_st);
        r.cr = int'(clamp32(gyro - bias_st));
        r.be = int'(bias_st);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", items_out, what, got, want);
        err_cnt++;
    endtask

    // input side: predict on every accepted item
    always @(posedge aclk) begin
        imu_out_t r;
        if (aresetn && s_valid && s_ready) begin
            r = kalman_step(longint'(s_accel_angle), longint'(s_gyro_rate));
            if (row_typed) r = row_exp;
            pending_q.push_back(r);
            items_in++;
        end
    end

    // output side: compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        imu_out_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                $display("unexpected result: angle %0d rate %0d bias %0d",
                         m_filtered_angle, m_corrected_rate, m_bias_estimate);
                err_cnt++;
            end else begin
                w = pending_q.pop_front();
                if (m_filtered_angle !== w.fa) report_mismatch("angle", m_filtered_angle, w.fa);
                if (m_corrected_rate !== w.cr) report_mismatch("rate", m_corrected_rate, w.cr);
                if (m_bias_estimate !== w.be) report_mismatch("bias", m_bias_estimate, w.be);
            end
            items_out++;
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        int span;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                hold_req = 1'b0;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_ready <= ($urandom_range(0, 7) == 0);
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 7) != 0);
                    end
                endcase
            end
        end
    end

    // offer one item and hold it until accepted; returns at a falling edge
    task automatic send_imu(input int accel, input int gyro, input bit typed,
                            input imu_out_t want);
        int gap;
        s_valid       <= 1'b1;
        s_accel_angle <= 25'(accel);
        s_gyro_rate   <= 28'(gyro);
        row_typed     <= typed;
        row_exp       <= want;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        // bursts with random gaps between them
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge aclk);
        repeat (5) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input longint val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[30:0];
        case (idx)
            abkf_pkg::REG_ANGLE_Q: q_angle = val & 64'h7fffffff;
            abkf_pkg::REG_BIAS_Q:  q_bias  = val & 64'h7fffffff;
            abkf_pkg::REG_MEAS_R:  r_meas  = val & 64'h7fffffff;
            default:               dt_step = val & 64'h7fffffff;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input longint qa, input longint qg, input longint rm,
                             input longint dt);
        write_reg(abkf_pkg::REG_ANGLE_Q, qa);
        write_reg(abkf_pkg::REG_BIAS_Q, qg);
        write_reg(abkf_pkg::REG_MEAS_R, rm);
        write_reg(abkf_pkg::REG_DT, dt);
    endtask

    function automatic int rand_span(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    initial begin
        imu_out_t none;
        imu_out_t zero;
        int phase;
        int accel, gyro;
        int track_ang, track_rate;
        none = '{0, 0, 0};
        zero = '{0, 0, 0};
        err_cnt = 0;
        items_in = 0;
        items_out = 0;
        hold_req = 1'b0;
        burst_left = 0;
        row_typed = 1'b0;
        row_exp = none;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_accel_angle = '0;
        s_gyro_rate = '0;
        reset_filter_model();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed rows: first one after reset settles at zero
        dir_tab.push_back('{0, 0, 1'b1, 0, 0, 0});
        dir_tab.push_back('{ACCEL_MAX, 0, 1'b0, 0, 0, 0});
        dir_tab.push_back('{-ACCEL_MAX, 0, 1'b0, 0, 0, 0});
        dir_tab.push_back('{0, GYRO_MAX, 1'b0, 0, 0, 0});
        dir_tab.push_back('{0, -GYRO_MAX, 1'b0, 0, 0, 0});
        dir_tab.push_back('{ACCEL_MAX, GYRO_MAX, 1'b0, 0, 0, 0});
        dir_tab.push_back('{-ACCEL_MAX, -GYRO_MAX, 1'b0, 0, 0, 0});
        dir_tab.push_back('{ACCEL_MAX, -GYRO_MAX, 1'b0, 0, 0, 0});
        dir_tab.push_back('{-ACCEL_MAX, GYRO_MAX, 1'b0, 0, 0, 0});
        dir_tab.push_back('{-1, -1, 1'b0, 0, 0, 0});
        dir_tab.push_back('{1, 1, 1'b0, 0, 0, 0});
        dir_tab.push_back('{655360, 3276800, 1'b0, 0, 0, 0});
        dir_tab.push_back('{655360, 3276800, 1'b0, 0, 0, 0});
        dir_tab.push_back('{-3276800, 0, 1'b0, 0, 0, 0});
        dir_tab.push_back('{0, 0, 1'b0, 0, 0, 0});
        foreach (dir_tab[i]) begin
            zero = '{dir_tab[i].fa, dir_tab[i].cr, dir_tab[i].be};
            send_imu(dir_tab[i].accel, dir_tab[i].gyro, dir_tab[i].typed, zero);
        end

        track_ang = 0;
        track_rate = 0;
        for (phase = 0; phase < 8; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                end
                1: begin
                    write_all(0, 0, 1, 1);
                end
                2: begin
                    write_all(64'd2147483647, 64'd2147483647, 64'd2147483647, 64'd1073741824);
                end
                3: begin
                    // zero sample period: prediction holds still
                    write_all(abkf_pkg::RST_ANGLE_Q, abkf_pkg::RST_BIAS_Q,
                              abkf_pkg::RST_MEAS_R, 0);
                end
                4: begin
                    write_all(64'd2147483647, 0, 1, 64'd1073741824);
                end
                7: begin
                    write_all(abkf_pkg::RST_ANGLE_Q, abkf_pkg::RST_BIAS_Q,
                              abkf_pkg::RST_MEAS_R, abkf_pkg::RST_DT);
                end
                default: begin
                    write_all($urandom_range(0, 32'h7fffffff), $urandom_range(0, 32'h7fffffff),
                              $urandom_range(1, 32'h7fffffff),
                              $urandom_range(1, 32'h40000000));
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 2 && n == 30) hold_req = 1'b1;
                if (phase == 5 && n == 50) wait_drained();
                if ($urandom_range(0, 9) < 7) begin
                    // smooth motion with sensor noise
                    track_rate = track_rate + rand_span(655360);
                    if (track_rate > GYRO_MAX / 4 || track_rate < -GYRO_MAX / 4) track_rate = 0;
                    track_ang = track_ang + track_rate / 100;
                    if (track_ang > ACCEL_MAX || track_ang < -ACCEL_MAX) track_ang = 0;
                    accel = track_ang + rand_span(131072);
                    if (accel > ACCEL_MAX) accel = ACCEL_MAX;
                    if (accel < -ACCEL_MAX) accel = -ACCEL_MAX;
                    gyro = track_rate + rand_span(65536);
                end else if ($urandom_range(0, 3) == 0) begin
                    accel = $urandom_range(0, 1) ? ACCEL_MAX : -ACCEL_MAX;
                    gyro = $urandom_range(0, 1) ? GYRO_MAX : -GYRO_MAX;
                end else begin
                    accel = rand_span(ACCEL_MAX);
                    gyro = rand_span(GYRO_MAX);
                end
                send_imu(accel, gyro, 1'b0, none);
            end
        end

        wait_drained();
        repeat (200) @(negedge aclk);
        $display("run covered %0d imu samples and %0d results over 8 noise/period settings",
                 items_in, items_out);
        $display("including extreme and zero sample periods and a long receiver stall");
        if (err_cnt == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
